// ===== hw/rtl/vcbr_pkg.sv =====
// Shared types and constants for the video capture buffer ring.
// Used by video_capture_buffer_ring and its testbench; depends on nothing.
package vcbr_pkg;

   localparam int NUM_SLOTS = 4;
   localparam int SLOT_W    = $clog2(NUM_SLOTS);
   localparam int ADDR_W    = 32;
   localparam int BASE_W    = 3 * ADDR_W;
   localparam int PITCH_W   = 16;
   localparam int STARTY_W  = 10;
   localparam int CSR_AW    = 4;
   localparam int CSR_DW    = 32;

   localparam logic                DONE_MASK    = 1'b1;
   localparam logic [STARTY_W-1:0] INVERT_BELOW = 10'd7;

   typedef enum logic [1:0] {
      OP_IRQ     = 2'd0,
      OP_RELEASE = 2'd1,
      OP_LOAD    = 2'd2,
      OP_START   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      REG_CAPTURE_FRAME = 2'd0,
      REG_START_Y       = 2'd1,
      REG_LUMA_PITCH    = 2'd2,
      REG_CHROMA_PITCH  = 2'd3
   } reg_index_type;

   localparam logic [1:0] ACK_NONE      = 2'd0;
   localparam logic [1:0] ACK_CAPTURE   = 2'd1;
   localparam logic [1:0] ACK_BANDWIDTH = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WORK = 2'b10
   } state_type;

endpackage

// ===== hw/rtl/vcbr_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
module vcbr_ram #(
   parameter int  WIDTH  = 8,
   parameter int  DEPTH  = 4,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/video_capture_buffer_ring.sv =====
// Top level of the video capture buffer ring: slot flags, ring pointer and CSRs.
// Depends on vcbr_pkg; slot bases live in a vcbr_ram instance.
//
//   port group   direction  handshake            contents
//   req_*        in         req_valid/req_stall  opcode, slot index, status, load bases
//   rsp_*        out        rsp_valid/rsp_stall  switch addresses, handed slot, ack kind
//   csr_*        in/out     APB psel/penable     capture_frame, start_y, pitches
//
// Each word is handled in two steps: the accept edge issues the base RAM read (or the
// load write), then the work state computes the result from the RAM read data.
// The next word is taken once the result is in the output register, so the
// block does not take a new word before it is through with the last one.
// Synchronous reset clears slot flags, ring pointer and the output valid; bases
// are unknown until loaded. A stalled result holds the block in its work state.
module video_capture_buffer_ring
   import vcbr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_opcode,
   input  logic [1:0]          req_buffer_index,
   input  logic                req_capture_done,
   input  logic                req_bandwidth_error,
   input  logic                req_odd_field,
   input  logic [ADDR_W-1:0]   req_load_y_base,
   input  logic [ADDR_W-1:0]   req_load_u_base,
   input  logic [ADDR_W-1:0]   req_load_v_base,
   input  logic                req_load_ready,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_switch_buffer,
   output logic [ADDR_W-1:0]   rsp_new_y_addr,
   output logic [ADDR_W-1:0]   rsp_new_u_addr,
   output logic [ADDR_W-1:0]   rsp_new_v_addr,
   output logic                rsp_frame_ready,
   output logic [1:0]          rsp_handed_index,
   output logic [1:0]          rsp_ack_kind,

   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CSR_AW-1:0]   csr_paddr,
   input  logic [CSR_DW-1:0]   csr_pwdata,
   output logic [CSR_DW-1:0]   csr_prdata,
   output logic                csr_pready
);

   // configuration registers
   logic                capture_frame_ff;
   logic [STARTY_W-1:0] start_y_ff;
   logic [PITCH_W-1:0]  luma_pitch_ff;
   logic [PITCH_W-1:0]  chroma_pitch_ff;
   logic                csr_write;
   reg_index_type       csr_index;

   // control state
   state_type           state_ff, state_in;
   logic [NUM_SLOTS-1:0] ready_ff, ready_in;
   logic [SLOT_W-1:0]   active_ff, active_in;
   logic                awaiting_ff, awaiting_in;

   // captured request word
   opcode_type          op_ff;
   logic [1:0]          idx_ff;
   logic                done_ff;
   logic                hbe_ff;
   logic                odd_ff;
   logic                load_ready_ff;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                switch_ff, switch_in;
   logic [ADDR_W-1:0]   y_addr_ff, y_addr_in;
   logic [ADDR_W-1:0]   u_addr_ff, u_addr_in;
   logic [ADDR_W-1:0]   v_addr_ff, v_addr_in;
   logic                frame_ready_ff, frame_ready_in;
   logic [1:0]          handed_ff, handed_in;
   logic [1:0]          ack_ff, ack_in;

   logic                req_accept;
   logic                out_free;
   logic                finish;
   logic [SLOT_W-1:0]   next_slot;
   logic                req_in_range;
   logic                held_in_range;
   logic [SLOT_W-1:0]   rd_slot;
   logic [BASE_W-1:0]   ram_rd_data;
   logic [ADDR_W-1:0]   rd_y, rd_u, rd_v;
   logic                odd_eff;

   // ---------------------------------------------------------------- CSRs
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         capture_frame_ff <= 1'b1;
         start_y_ff       <= 10'd23;
         luma_pitch_ff    <= '0;
         chroma_pitch_ff  <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_CAPTURE_FRAME: capture_frame_ff <= csr_pwdata[0];
            REG_START_Y:       start_y_ff       <= csr_pwdata[STARTY_W-1:0];
            REG_LUMA_PITCH:    luma_pitch_ff    <= csr_pwdata[PITCH_W-1:0];
            REG_CHROMA_PITCH:  chroma_pitch_ff  <= csr_pwdata[PITCH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_CAPTURE_FRAME: csr_prdata = {31'd0, capture_frame_ff};
         REG_START_Y:       csr_prdata = {22'd0, start_y_ff};
         REG_LUMA_PITCH:    csr_prdata = {16'd0, luma_pitch_ff};
         REG_CHROMA_PITCH:  csr_prdata = {16'd0, chroma_pitch_ff};
         default:           csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- accept
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid & ~req_stall;

   assign req_in_range  = ({30'd0, req_buffer_index} < 32'(NUM_SLOTS));
   assign held_in_range = ({30'd0, idx_ff} < 32'(NUM_SLOTS));

   assign next_slot = (active_ff == SLOT_W'(NUM_SLOTS - 1)) ? '0
                                                            : active_ff + SLOT_W'(1);

   // frame mode waiting for its first field reads the current slot, else the next
   assign rd_slot = (capture_frame_ff & awaiting_ff) ? active_ff : next_slot;

   vcbr_ram #(
      .WIDTH (BASE_W),
      .DEPTH (NUM_SLOTS)
   ) u_base_ram (
      .clock   (clock),
      .wr_en   (req_accept & (req_opcode == OP_LOAD) & req_in_range),
      .wr_addr (SLOT_W'(req_buffer_index)),
      .wr_data ({req_load_y_base, req_load_u_base, req_load_v_base}),
      .rd_en   (req_accept),
      .rd_addr (rd_slot),
      .rd_data (ram_rd_data)
   );

   assign rd_y = ram_rd_data[3*ADDR_W-1:2*ADDR_W];
   assign rd_u = ram_rd_data[2*ADDR_W-1:ADDR_W];
   assign rd_v = ram_rd_data[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff         <= opcode_type'(req_opcode);
         idx_ff        <= req_buffer_index;
         done_ff       <= req_capture_done;
         hbe_ff        <= req_bandwidth_error;
         odd_ff        <= req_odd_field;
         load_ready_ff <= req_load_ready;
      end
   end

   // ---------------------------------------------------------------- update
   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign finish   = (state_ff == ST_WORK) & out_free;
   assign odd_eff  = odd_ff ^ (start_y_ff < INVERT_BELOW);

   always_comb begin
      state_in       = state_ff;
      ready_in       = ready_ff;
      active_in      = active_ff;
      awaiting_in    = awaiting_ff;
      switch_in      = 1'b0;
      y_addr_in      = '0;
      u_addr_in      = '0;
      v_addr_in      = '0;
      frame_ready_in = 1'b0;
      handed_in      = '0;
      ack_in         = ACK_NONE;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_WORK;
            end
         end
         ST_WORK: begin
            if (out_free) begin
               state_in = ST_IDLE;
               case (op_ff)
                  OP_RELEASE: begin
                     if (held_in_range) begin
                        ready_in[SLOT_W'(idx_ff)] = 1'b1;
                     end
                  end
                  OP_LOAD: begin
                     if (held_in_range) begin
                        ready_in[SLOT_W'(idx_ff)] = load_ready_ff;
                     end
                  end
                  OP_START: begin
                     active_in   = '0;
                     awaiting_in = 1'b1;
                  end
                  OP_IRQ: begin
                     if ((done_ff & DONE_MASK) == 1'b0) begin
                        ack_in = ACK_NONE;
                     end else if (hbe_ff) begin
                        ack_in = ACK_BANDWIDTH;
                     end else begin
                        ack_in = ACK_CAPTURE;
                        if (capture_frame_ff & awaiting_ff) begin
                           // move to the second-field addresses of the current slot
                           if (odd_eff) begin
                              awaiting_in = 1'b0;
                              switch_in   = 1'b1;
                              y_addr_in   = rd_y + {16'd0, luma_pitch_ff};
                              u_addr_in   = rd_u + {16'd0, chroma_pitch_ff};
                              v_addr_in   = rd_v + {16'd0, chroma_pitch_ff};
                           end
                        end else if ((odd_eff | capture_frame_ff) && ready_ff[next_slot]) begin
                           // advance the ring and hand the filled slot over
                           switch_in           = 1'b1;
                           y_addr_in           = rd_y;
                           u_addr_in           = rd_u;
                           v_addr_in           = rd_v;
                           ready_in[active_ff] = 1'b0;
                           frame_ready_in      = 1'b1;
                           handed_in           = 2'(active_ff);
                           active_in           = next_slot;
                           if (capture_frame_ff) begin
                              awaiting_in = 1'b1;
                           end
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = finish | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ready_ff     <= '0;
         active_ff    <= '0;
         awaiting_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ready_ff     <= ready_in;
         active_ff    <= active_in;
         awaiting_ff  <= awaiting_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         switch_ff      <= switch_in;
         y_addr_ff      <= y_addr_in;
         u_addr_ff      <= u_addr_in;
         v_addr_ff      <= v_addr_in;
         frame_ready_ff <= frame_ready_in;
         handed_ff      <= handed_in;
         ack_ff         <= ack_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_switch_buffer = switch_ff;
   assign rsp_new_y_addr    = y_addr_ff;
   assign rsp_new_u_addr    = u_addr_ff;
   assign rsp_new_v_addr    = v_addr_ff;
   assign rsp_frame_ready   = frame_ready_ff;
   assign rsp_handed_index  = handed_ff;
   assign rsp_ack_kind      = ack_ff;

endmodule

// ===== tb/video_capture_buffer_ring_tb.sv =====
// Self-checking bench for video_capture_buffer_ring: scoreboard class, word driver,
// APB register writes and a stalling result sink.
// Depends on vcbr_pkg and the video_capture_buffer_ring RTL.
module video_capture_buffer_ring_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import vcbr_pkg::*;

   localparam int LIMIT_CYCLES = 400000;
   localparam int LONG_HOLD    = 300;
   localparam int RANDOM_WORDS = 1500;
   localparam int PHASES       = 6;

   typedef enum int {STALL_NONE, STALL_SPARSE, STALL_RUNS} stall_mode_type;

   typedef struct packed {
      opcode_type        op;
      logic [1:0]        slot;
      logic              done;
      logic              bw_err;
      logic              odd;
      logic [ADDR_W-1:0] y_base;
      logic [ADDR_W-1:0] u_base;
      logic [ADDR_W-1:0] v_base;
      logic              ready;
   } capture_word_type;

   typedef struct packed {
      logic              switch_buf;
      logic [ADDR_W-1:0] y_addr;
      logic [ADDR_W-1:0] u_addr;
      logic [ADDR_W-1:0] v_addr;
      logic              frame_ready;
      logic [1:0]        handed;
      logic [1:0]        ack;
   } ring_answer_type;

   class ring_scoreboard;
      bit                capture_frame = 1'b1;
      bit [STARTY_W-1:0] start_y = 10'd23;
      bit [PITCH_W-1:0]  luma_pitch;
      bit [PITCH_W-1:0]  chroma_pitch;
      bit                slot_ready [NUM_SLOTS];
      bit [ADDR_W-1:0]   y_base [NUM_SLOTS];
      bit [ADDR_W-1:0]   u_base [NUM_SLOTS];
      bit [ADDR_W-1:0]   v_base [NUM_SLOTS];
      int unsigned       active_slot;
      bit                awaiting_first = 1'b1;
      ring_answer_type   awaited [$];
      int unsigned       errors, words, checked, switches, handoffs, bw_acks, spurious;

      function void write_reg(reg_index_type idx, bit [CSR_DW-1:0] value);
         case (idx)
            REG_CAPTURE_FRAME: capture_frame = value[0];
            REG_START_Y:       start_y = value[STARTY_W-1:0];
            REG_LUMA_PITCH:    luma_pitch = value[PITCH_W-1:0];
            REG_CHROMA_PITCH:  chroma_pitch = value[PITCH_W-1:0];
            default: ;
         endcase
      endfunction

      // Move to the next slot if it is ready; hand the current one over.
      function bit step_ring(inout ring_answer_type a);
         int unsigned cur, nxt;
         cur = active_slot % NUM_SLOTS;
         nxt = (cur + 1) % NUM_SLOTS;
         if (!slot_ready[nxt]) return 1'b0;
         a.switch_buf  = 1'b1;
         a.y_addr      = y_base[nxt];
         a.u_addr      = u_base[nxt];
         a.v_addr      = v_base[nxt];
         a.frame_ready = 1'b1;
         a.handed      = 2'(cur);
         slot_ready[cur] = 1'b0;
         active_slot = nxt;
         switches++;
         handoffs++;
         return 1'b1;
      endfunction

      function void note_word(capture_word_type w);
         ring_answer_type a;
         bit              odd;
         int unsigned     cur;
         a = '0;
         words++;
         case (w.op)
            OP_RELEASE: if (int'(w.slot) < NUM_SLOTS) slot_ready[w.slot] = 1'b1;
            OP_LOAD: if (int'(w.slot) < NUM_SLOTS) begin
               y_base[w.slot] = w.y_base;
               u_base[w.slot] = w.u_base;
               v_base[w.slot] = w.v_base;
               slot_ready[w.slot] = w.ready;
            end
            OP_START: begin
               active_slot = 0;
               awaiting_first = 1'b1;
            end
            default: begin
               // early start lines swap field parity
               odd = w.odd ^ (start_y < INVERT_BELOW);
               if ((w.done & DONE_MASK) == 1'b0) begin
                  spurious++;
               end else if (w.bw_err) begin
                  a.ack = ACK_BANDWIDTH;
                  bw_acks++;
               end else begin
                  if (!capture_frame) begin
                     if (odd) void'(step_ring(a));
                  end else if (awaiting_first) begin
                     if (odd) begin
                        cur = active_slot % NUM_SLOTS;
                        awaiting_first = 1'b0;
                        a.switch_buf = 1'b1;
                        a.y_addr = y_base[cur] + ADDR_W'(luma_pitch);
                        a.u_addr = u_base[cur] + ADDR_W'(chroma_pitch);
                        a.v_addr = v_base[cur] + ADDR_W'(chroma_pitch);
                        switches++;
                     end
                  end else if (step_ring(a)) begin
                     awaiting_first = 1'b1;
                  end
                  a.ack = ACK_CAPTURE;
               end
            end
         endcase
         awaited.push_back(a);
      endfunction

      function void check_field(string name, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
         end
      endfunction

      function void check_result(ring_answer_type got);
         ring_answer_type want;
         if (awaited.size() == 0) begin
            errors++;
            $display("%0t: result word with nothing pending: expected none, actual %h",
                     $time, got);
            return;
         end
         want = awaited.pop_front();
         checked++;
         check_field("switch_buffer", ADDR_W'(want.switch_buf), ADDR_W'(got.switch_buf));
         check_field("new_y_addr", want.y_addr, got.y_addr);
         check_field("new_u_addr", want.u_addr, got.u_addr);
         check_field("new_v_addr", want.v_addr, got.v_addr);
         check_field("frame_ready", ADDR_W'(want.frame_ready), ADDR_W'(got.frame_ready));
         check_field("handed_index", ADDR_W'(want.handed), ADDR_W'(got.handed));
         check_field("ack_kind", ADDR_W'(want.ack), ADDR_W'(got.ack));
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [1:0]          req_opcode;
   logic [1:0]          req_buffer_index;
   logic                req_capture_done;
   logic                req_bandwidth_error;
   logic                req_odd_field;
   logic [ADDR_W-1:0]   req_load_y_base;
   logic [ADDR_W-1:0]   req_load_u_base;
   logic [ADDR_W-1:0]   req_load_v_base;
   logic                req_load_ready;
   logic                rsp_valid;
   logic                rsp_stall;
   logic                rsp_switch_buffer;
   logic [ADDR_W-1:0]   rsp_new_y_addr;
   logic [ADDR_W-1:0]   rsp_new_u_addr;
   logic [ADDR_W-1:0]   rsp_new_v_addr;
   logic                rsp_frame_ready;
   logic [1:0]          rsp_handed_index;
   logic [1:0]          rsp_ack_kind;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [CSR_AW-1:0]   csr_paddr;
   logic [CSR_DW-1:0]   csr_pwdata;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   ring_scoreboard sb = new();
   stall_mode_type stall_mode = STALL_NONE;
   int unsigned    hold_asks, holds_done, hold_left, run_left;
   bit             run_stall;
   int unsigned    cycles;

   video_capture_buffer_ring dut (.*);

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT_CYCLES) begin
         $display("%0t: watchdog expired with %0d results pending", $time, sb.awaited.size());
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result({rsp_switch_buffer, rsp_new_y_addr, rsp_new_u_addr, rsp_new_v_addr,
                          rsp_frame_ready, rsp_handed_index, rsp_ack_kind});
   end

   // Result sink: long hold on request, otherwise the pattern of the phase.
   always @(negedge clock) begin
      if (hold_left == 0 && holds_done != hold_asks) hold_left = LONG_HOLD;
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left--;
         if (hold_left == 0) holds_done++;
      end else begin
         case (stall_mode)
            STALL_NONE:   rsp_stall = 1'b0;
            STALL_SPARSE: rsp_stall = ($urandom_range(0, 3) == 0);
            default: begin
               if (run_left == 0) begin
                  run_stall = ($urandom_range(0, 2) == 0);
                  run_left = $urandom_range(1, 8);
               end
               rsp_stall = run_stall;
               run_left--;
            end
         endcase
      end
   end

   function automatic capture_word_type make_word(opcode_type op, logic [1:0] slot, logic done,
                                                  logic bw_err, logic odd, logic [ADDR_W-1:0] y,
                                                  logic [ADDR_W-1:0] u, logic [ADDR_W-1:0] v,
                                                  logic ready);
      capture_word_type w;
      w = '{op, slot, done, bw_err, odd, y, u, v, ready};
      return w;
   endfunction

   function automatic capture_word_type random_word();
      capture_word_type w;
      int unsigned      pick;
      pick = $urandom_range(0, 99);
      w.op     = pick < 50 ? OP_IRQ : pick < 78 ? OP_RELEASE : pick < 96 ? OP_LOAD : OP_START;
      w.slot   = 2'($urandom_range(0, 3));
      w.done   = ($urandom_range(0, 9) != 0);
      w.bw_err = ($urandom_range(0, 9) == 0);
      w.odd    = 1'($urandom_range(0, 1));
      w.y_base = $urandom;
      w.u_base = $urandom;
      w.v_base = $urandom;
      w.ready  = ($urandom_range(0, 3) != 0);
      return w;
   endfunction

   task automatic send_word(capture_word_type w);
      @(negedge clock);
      req_valid           = 1'b1;
      req_opcode          = w.op;
      req_buffer_index    = w.slot;
      req_capture_done    = w.done;
      req_bandwidth_error = w.bw_err;
      req_odd_field       = w.odd;
      req_load_y_base     = w.y_base;
      req_load_u_base     = w.u_base;
      req_load_v_base     = w.v_base;
      req_load_ready      = w.ready;
      do @(posedge clock); while (req_stall);
      sb.note_word(w);
   endtask

   task automatic idle_sender(int unsigned n);
      if (n > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic csr_write(reg_index_type idx, logic [CSR_DW-1:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = CSR_AW'(4 * idx);
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.write_reg(idx, value);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // Drop valid, drain the block, then rewrite every register.
   task automatic configure(logic frame, logic [STARTY_W-1:0] sy, logic [PITCH_W-1:0] lp,
                            logic [PITCH_W-1:0] cp);
      idle_sender(1);
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write(REG_CAPTURE_FRAME, CSR_DW'(frame));
      csr_write(REG_START_Y, CSR_DW'(sy));
      csr_write(REG_LUMA_PITCH, CSR_DW'(lp));
      csr_write(REG_CHROMA_PITCH, CSR_DW'(cp));
   endtask

   task automatic send_directed(capture_word_type w);
      send_word(w);
      idle_sender($urandom_range(0, 2));
   endtask

   initial begin
      int unsigned sent, burst;
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_IRQ;
      req_buffer_index = '0;
      req_capture_done = 1'b0;
      req_bandwidth_error = 1'b0;
      req_odd_field = 1'b0;
      req_load_y_base = '0;
      req_load_u_base = '0;
      req_load_v_base = '0;
      req_load_ready = 1'b0;
      rsp_stall = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Fill every slot first so no switch ever reads an unloaded base.
      send_directed(make_word(OP_LOAD, 2'd0, 0, 0, 0, '0, '0, '0, 1));
      send_directed(make_word(OP_LOAD, 2'd1, 0, 0, 0, '1, '1, '1, 1));
      send_directed(make_word(OP_LOAD, 2'd2, 0, 0, 0, $urandom, $urandom, $urandom, 0));
      send_directed(make_word(OP_LOAD, 2'd3, 0, 0, 0, $urandom, $urandom, $urandom, 1));
      // frame mode at reset settings
      send_directed(make_word(OP_IRQ, 2'd0, 0, 1, 1, '0, '0, '0, 0));
      send_directed(make_word(OP_IRQ, 2'd0, 1, 1, 1, '0, '0, '0, 0));
      send_directed(make_word(OP_IRQ, 2'd0, 1, 0, 0, '0, '0, '0, 0));
      send_directed(make_word(OP_IRQ, 2'd0, 1, 0, 1, '0, '0, '0, 0));
      send_directed(make_word(OP_IRQ, 2'd0, 1, 0, 0, '0, '0, '0, 0));
      send_directed(make_word(OP_RELEASE, 2'd0, 0, 0, 0, '0, '0, '0, 0));
      send_directed(make_word(OP_START, 2'd0, 0, 0, 0, '0, '0, '0, 0));
      // field mode with parity inverted
      configure(1'b0, 10'd0, 16'hffff, 16'hffff);
      send_directed(make_word(OP_IRQ, 2'd0, 1, 0, 0, '0, '0, '0, 0));
      send_directed(make_word(OP_IRQ, 2'd0, 1, 0, 1, '0, '0, '0, 0));
      send_directed(make_word(OP_IRQ, 2'd0, 1, 0, 0, '0, '0, '0, 0));
      send_directed(make_word(OP_RELEASE, 2'd2, 0, 0, 0, '0, '0, '0, 0));
      send_directed(make_word(OP_IRQ, 2'd0, 1, 0, 0, '0, '0, '0, 0));
      // frame mode, second-field sums that wrap
      configure(1'b1, 10'd6, 16'hffff, 16'hffff);
      send_directed(make_word(OP_START, 2'd3, 0, 0, 0, '0, '0, '0, 0));
      send_directed(make_word(OP_LOAD, 2'd0, 0, 0, 0, 32'hffff_fff0, 32'hffff_ffff,
                              32'h0001_0000, 1));
      send_directed(make_word(OP_IRQ, 2'd0, 1, 0, 0, '0, '0, '0, 0));
      send_directed(make_word(OP_IRQ, 2'd0, 1, 0, 1, '0, '0, '0, 0));
      send_directed(make_word(OP_RELEASE, 2'd1, 0, 0, 0, '0, '0, '0, 0));
      send_directed(make_word(OP_IRQ, 2'd0, 1, 0, 1, '0, '0, '0, 0));
      send_directed(make_word(OP_RELEASE, 2'd3, 0, 0, 0, '0, '0, '0, 0));

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin
               configure(1'b1, 10'd7, 16'h0001, 16'h8000);
               stall_mode = STALL_NONE;
            end
            1: begin
               configure(1'b0, 10'd1023, 16'($urandom), 16'($urandom));
               stall_mode = STALL_SPARSE;
            end
            2: begin
               configure(1'b1, 10'd23, 16'hffff, 16'h0000);
               stall_mode = STALL_RUNS;
            end
            3: begin
               configure(1'b0, 10'd6, 16'h0000, 16'hffff);
               stall_mode = STALL_RUNS;
            end
            default: begin
               configure(1'($urandom_range(0, 1)), 10'($urandom_range(0, 12)),
                         16'($urandom), 16'($urandom));
               stall_mode = stall_mode_type'($urandom_range(0, 2));
            end
         endcase
         sent = 0;
         while (sent < RANDOM_WORDS / PHASES) begin
            burst = $urandom_range(1, 16);
            repeat (burst) begin
               send_word(random_word());
               sent++;
               // sink holds off while words keep coming
               if (ph == 2 && sent == 60) hold_asks++;
            end
            if (ph != 0) idle_sender($urandom_range(0, 6));
         end
      end

      idle_sender(1);
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("%0d words sent, %0d results checked: %0d address switches, %0d hand-offs,",
               sb.words, sb.checked, sb.switches, sb.handoffs);
      $display("%0d bandwidth acks, %0d spurious interrupts over field and frame settings",
               sb.bw_acks, sb.spurious);
      if (sb.errors == 0 && sb.awaited.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
